// ----- src/wss_pkg.sv -----
`timescale 1ns / 1ps

package wss_pkg;

	// Field widths of the item and result channels
	localparam int BYTE_W   = 8;
	localparam int POS_W    = 16;
	localparam int START_W  = POS_W + 1;
	localparam int NL_W     = 6;
	localparam int WORD_W   = 64;
	localparam int N_WORDS  = 4;
	localparam int CFG_IDX_W = 3;
	// Width that holds any count, cursor or length without loss
	localparam int EXT_W    = 24;

	localparam int NEEDLE_MAX_DEF = 32;
	localparam int TEXT_MAX_DEF   = 65536;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Configuration register indexes
	localparam cfg_idx_t CFG_NEEDLE_LEN = 3'd0;
	localparam cfg_idx_t CFG_WORD_0     = 3'd1;
	localparam cfg_idx_t CFG_WORD_1     = 3'd2;
	localparam cfg_idx_t CFG_WORD_2     = 3'd3;
	localparam cfg_idx_t CFG_WORD_3     = 3'd4;

	typedef logic [N_WORDS-1:0][WORD_W-1:0] needle_words_t;

	// Item held in the tracking stage
	typedef struct packed {
		logic               valid;
		logic               last;
		logic               took;
		logic [START_W-1:0] start;
	} stage_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] match_pos;
		logic             wrapped;
	} result_t;

	// Needle byte i, byte 0 in the low bits of word 0
	function automatic logic [BYTE_W-1:0] needle_byte(needle_words_t words, logic [4:0] idx);
		logic [WORD_W-1:0] w;
		w = words[idx[4:3]];
		return w[idx[2:0]*BYTE_W +: BYTE_W];
	endfunction

endpackage

// ----- src/wss_in_if.sv -----
`timescale 1ns / 1ps

interface wss_in_if;
	import wss_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] text_byte;
	logic              byte_present;
	logic [POS_W-1:0]  cursor_pos;
	logic              last_item;

	modport source (output valid, output text_byte, output byte_present,
		output cursor_pos, output last_item, input ready);
	modport sink (input valid, input text_byte, input byte_present,
		input cursor_pos, input last_item, output ready);
endinterface

// ----- src/wss_out_if.sv -----
`timescale 1ns / 1ps

interface wss_out_if;
	import wss_pkg::*;

	logic             valid;
	logic             ready;
	logic             found;
	logic [POS_W-1:0] match_pos;
	logic             wrapped;

	modport source (output valid, output found, output match_pos, output wrapped,
		input ready);
	modport sink (input valid, input found, input match_pos, input wrapped,
		output ready);
endinterface

// ----- src/wss_cfg_if.sv -----
`timescale 1ns / 1ps

interface wss_cfg_if;
	import wss_pkg::*;

	logic              valid;
	logic              ready;
	logic [CFG_IDX_W-1:0] index;
	logic [WORD_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/wss_cell.sv -----
`timescale 1ns / 1ps

// One window position: holds a text byte, passes it on, compares it
module wss_cell (
	input  logic                      clk,
	input  logic                      shift,
	input  logic [wss_pkg::BYTE_W-1:0] din,
	input  logic [wss_pkg::BYTE_W-1:0] needle,
	input  logic                      active,
	output logic [wss_pkg::BYTE_W-1:0] dout,
	output logic                      hit
);
	import wss_pkg::*;

	logic [BYTE_W-1:0] byte_q;

	// window byte, moves one place on each taken text byte
	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= din;
		end
	end

	assign dout = byte_q;
	// positions beyond the needle length do not take part
	assign hit  = !active || (byte_q == needle);
endmodule

// ----- src/wss_tracker.sv -----
`timescale 1ns / 1ps

// Match detection and first-match tracking; builds the result of a run
module wss_tracker #(
	parameter int NEEDLE_MAX = wss_pkg::NEEDLE_MAX_DEF,
	parameter int TEXT_MAX   = wss_pkg::TEXT_MAX_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  wss_pkg::stage_t                  st,
	input  logic [$clog2(TEXT_MAX+1)-1:0]    count,
	input  logic [wss_pkg::NL_W-1:0]         nl,
	input  logic                             all_hit,
	output logic                             push,
	output wss_pkg::result_t                 res
);
	import wss_pkg::*;

	logic             any_q, later_q;
	logic [POS_W-1:0] any_pos_q, later_pos_q;

	logic             usable, match;
	logic [EXT_W-1:0] count_x, nl_x, start_x, pos_x;
	logic             any_n, later_n;
	logic [POS_W-1:0] any_pos_n, later_pos_n;

	assign count_x = EXT_W'(count);
	assign nl_x    = EXT_W'(nl);
	assign start_x = EXT_W'(st.start);
	assign pos_x   = count_x - nl_x;
	assign usable  = (nl != '0) && (nl_x <= EXT_W'(NEEDLE_MAX));

	// needle ends at the byte this item brought in
	assign match = st.took && usable && (count_x >= nl_x) && all_hit;

	always_comb begin
		any_n       = any_q;
		any_pos_n   = any_pos_q;
		later_n     = later_q;
		later_pos_n = later_pos_q;
		if (match && !any_q) begin
			any_n     = 1'b1;
			any_pos_n = pos_x[POS_W-1:0];
		end
		if (match && !later_q && (pos_x >= start_x)) begin
			later_n     = 1'b1;
			later_pos_n = pos_x[POS_W-1:0];
		end
	end

	// result choice at the end of a run
	always_comb begin
		res = '0;
		if (usable && (nl_x <= count_x)) begin
			priority if (start_x > count_x) begin
				if (any_n) begin
					res.found     = 1'b1;
					res.match_pos = any_pos_n;
				end
			end else if (later_n) begin
				res.found     = 1'b1;
				res.match_pos = later_pos_n;
			end else begin
				if (any_n) begin
					res.found     = 1'b1;
					res.match_pos = any_pos_n;
					res.wrapped   = 1'b1;
				end
			end
		end
	end

	assign push = st.valid && st.last;

	// run state, cleared when the result is pushed to the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q       <= 1'b0;
			later_q     <= 1'b0;
			any_pos_q   <= '0;
			later_pos_q <= '0;
		end else if (st.valid) begin
			if (st.last) begin
				any_q       <= 1'b0;
				later_q     <= 1'b0;
				any_pos_q   <= '0;
				later_pos_q <= '0;
			end else begin
				any_q       <= any_n;
				later_q     <= later_n;
				any_pos_q   <= any_pos_n;
				later_pos_q <= later_pos_n;
			end
		end
	end

`ifndef SYNTHESIS
	a_later_implies_any: assert property (@(posedge clk) disable iff (!arst_n)
		later_q |-> any_q)
		else $error("later match recorded without a first match");
	a_later_not_before_any: assert property (@(posedge clk) disable iff (!arst_n)
		later_q |-> (later_pos_q >= any_pos_q))
		else $error("later match lies before the first match");
	a_run_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (!any_q && !later_q))
		else $error("run state not cleared after a result");
`endif
endmodule

// ----- src/wss_outq.sv -----
`timescale 1ns / 1ps

// Two-entry result queue: output register and skid slot
module wss_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wss_pkg::result_t  din,
	output logic [1:0]        fill,
	wss_out_if.source         result
);
	import wss_pkg::*;

	result_t    head_q, skid_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop  = result.valid && result.ready;
	assign fill = cnt_q;

	assign result.valid     = (cnt_q != 2'd0);
	assign result.found     = head_q.found;
	assign result.match_pos = head_q.match_pos;
	assign result.wrapped   = head_q.wrapped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// payload slots
	always_ff @(posedge clk) begin
		if (pop) begin
			if (cnt_q == 2'd2) begin
				head_q <= skid_q;
				if (push) begin
					skid_q <= din;
				end
			end else if (push) begin
				head_q <= din;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				head_q <= din;
			end else begin
				skid_q <= din;
			end
		end
	end

`ifndef SYNTHESIS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue fill out of range");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !((cnt_q == 2'd2) && !pop))
		else $error("result pushed into a full queue");
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.found) |-> (result.match_pos == '0 && !result.wrapped))
		else $error("result without match carries a position");
`endif
endmodule

// ----- src/wrapping_substring_search_top.sv -----
`timescale 1ns / 1ps

// Streaming needle search with wrap-around "find next". Text bytes enter one item per
// cycle into a chain of NEEDLE_MAX window cells, each comparing its byte with the
// matching needle byte; the cycle after an item, the tracking stage records the first
// match overall and the first match at or after cursor_pos+1. The result of a run is
// valid on the result channel from the clock edge after the one that accepts its last
// item. The block takes an item every cycle while the result queue (output register
// plus one skid slot) has room; ready falls only while the sink stalls and the queue,
// counting a result in flight, would be full. Needle registers may be written between
// runs once the previous item has cleared the tracking stage. No clearing pass after
// reset.
module wrapping_substring_search_top #(
	parameter int NEEDLE_MAX = wss_pkg::NEEDLE_MAX_DEF,
	parameter int TEXT_MAX   = wss_pkg::TEXT_MAX_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	wss_cfg_if.sink   cfg,
	wss_in_if.sink    text,
	wss_out_if.source result
);
	import wss_pkg::*;

	localparam int CNT_W = $clog2(TEXT_MAX + 1);

	logic [NL_W-1:0] nl_q;
	needle_words_t   words_q;

	logic [CNT_W-1:0] count_q, count_base;
	stage_t           st_s1;
	logic             acc, run_end, shift;
	logic [1:0]       fill;
	logic             push;
	logic             pop;
	result_t          res;

	logic [NEEDLE_MAX-1:0][BYTE_W-1:0] win;
	logic [NEEDLE_MAX-1:0]             hits;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nl_q    <= '0;
			words_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_NEEDLE_LEN: nl_q       <= cfg.data[NL_W-1:0];
				CFG_WORD_0:     words_q[0] <= cfg.data;
				CFG_WORD_1:     words_q[1] <= cfg.data;
				CFG_WORD_2:     words_q[2] <= cfg.data;
				CFG_WORD_3:     words_q[3] <= cfg.data;
				default:        ;
			endcase
		end
	end

	// room for a result: queue fill plus a last item in the tracking stage, less a result
	// leaving this cycle
	assign pop        = result.valid && result.ready;
	assign text.ready = ({1'b0, fill} + {2'b00, push}) < ({2'b00, pop} + 3'd2);
	assign acc        = text.valid && text.ready;
	assign run_end    = st_s1.valid && st_s1.last;
	assign count_base = run_end ? '0 : count_q;
	assign shift      = acc && text.byte_present && (count_base < CNT_W'(TEXT_MAX));

	// byte count of the run, restarting after a last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (shift) begin
			count_q <= count_base + CNT_W'(1);
		end else if (run_end) begin
			count_q <= '0;
		end
	end

	// tracking stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1 <= '0;
		end else begin
			st_s1.valid <= acc;
			st_s1.last  <= acc && text.last_item;
			st_s1.took  <= shift;
			st_s1.start <= START_W'(text.cursor_pos) + START_W'(1);
		end
	end

	// window cells, newest byte in cell 0
	for (genvar k = 0; k < NEEDLE_MAX; k++) begin : g_cell
		logic [BYTE_W-1:0] din;
		logic              active;
		logic [4:0]        nidx;

		if (k == 0) begin : g_head
			assign din = text.text_byte;
		end else begin : g_link
			assign din = win[k-1];
		end

		assign active = (NL_W'(k) < nl_q);
		assign nidx   = 5'(nl_q - NL_W'(k + 1));

		wss_cell u_cell (
			.clk    (clk),
			.shift  (shift),
			.din    (din),
			.needle (needle_byte(words_q, nidx)),
			.active (active),
			.dout   (win[k]),
			.hit    (hits[k])
		);
	end

	wss_tracker #(
		.NEEDLE_MAX (NEEDLE_MAX),
		.TEXT_MAX   (TEXT_MAX)
	) u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.st      (st_s1),
		.count   (count_q),
		.nl      (nl_q),
		.all_hit (&hits),
		.push    (push),
		.res     (res)
	);

	wss_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (res),
		.fill   (fill),
		.result (result)
	);
endmodule
